// ===== rtl/core/vprf_pkg.sv =====
// Shared constants and codes of the variable packet ring FIFO.
package vprf_pkg;

  // Default geometry of the ring.
  localparam int unsigned BufferBytesDef = 2048;
  localparam int unsigned HeaderBytesDef = 8;

  // Width of the adder used for all ring position sums.
  localparam int unsigned SUM_W = 18;

  // Item field widths.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned META_W   = 48;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFS_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 88;

  // Operation codes carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_PUSH_START = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BYTE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ_HDR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_BYTE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP        = 3'd4;

  // Result status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SEQ_ERR  = 2'd3;

endpackage

// ===== rtl/core/vprf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module vprf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/variable_packet_ring_fifo_top.sv =====
// Variable-length packet FIFO kept in one byte-wide ring memory.
//
// Usage: every input item carries an operation in s_axis_tuser (push start,
// push payload byte, read front header, read front payload byte, pop) and its
// arguments in s_axis_tdata. Every item yields exactly one result item on the
// master side, with the status in m_axis_tuser and the front header, the byte
// read, the committed byte count and the empty flag in m_axis_tdata.
// A packet is stored as a header of HEADER_BYTES bytes followed by its payload;
// its size is committed once its last payload byte has been written.
// The single memory port moves one header byte per cycle: a push start
// writes the header bytes in order, while a header read, a pop and a payload
// byte read first read the header back, each byte coming out of the registered
// read port; a payload byte read inside the front length then reads that byte.
// One item is worked on at a time.
// A finished result sits in an output register, so the next item is taken
// while it waits; a further result waits in the sequencer until the receiver
// takes the held one. Reset empties the FIFO and drops any open push; the
// ring contents need no clearing because only committed bytes are read.
module variable_packet_ring_fifo_top #(
  parameter int unsigned BUFFER_BYTES = vprf_pkg::BufferBytesDef,
  parameter int unsigned HEADER_BYTES = vprf_pkg::HeaderBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // header_meta [47:0], payload_len [63:48], in_byte [71:64], byte_offset [82:72]
  input  logic [vprf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode [2:0]
  input  logic [vprf_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // front_meta [47:0], front_len [63:48], out_byte [71:64], used_bytes [82:72],
  // is_empty [83]
  output logic [vprf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [vprf_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import vprf_pkg::*;

  localparam int unsigned PTR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned HC_W  = $clog2(HEADER_BYTES + 1);
  localparam int unsigned NMETA = ((HEADER_BYTES - 2) < 6) ? (HEADER_BYTES - 2) : 6;
  localparam logic [SUM_W-1:0] BUF_SIZE = SUM_W'(BUFFER_BYTES);
  localparam logic [SUM_W-1:0] HDR_SIZE = SUM_W'(HEADER_BYTES);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECIDE   = 7'b0000010,
    S_HDR_WR   = 7'b0000100,
    S_HDR_RD   = 7'b0001000,
    S_HDR_DONE = 7'b0010000,
    S_BYTE_RD  = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_e;

  // Position in the ring, base plus an offset known to stay below the size.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [SUM_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + ofs;
    if (sum >= BUF_SIZE) begin
      sum = sum - BUF_SIZE;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Control state.
  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [PTR_W-1:0]  used_q, used_d;
  logic [LEN_W-1:0]  pend_q, pend_d;
  logic              open_q, open_d;
  logic [LEN_W:0]    psize_q, psize_d;
  logic [HC_W-1:0]   cnt_q, cnt_d;
  logic              m_valid_q, m_valid_d;

  // Latched item and working registers.
  logic [MODE_W-1:0]   mode_q;
  logic [META_W-1:0]   meta_in_q;
  logic [LEN_W-1:0]    len_in_q;
  logic [BYTE_W-1:0]   byte_in_q;
  logic [OFS_W-1:0]    ofs_q;
  logic [META_W-1:0]   hmeta_q, hmeta_d;
  logic [LEN_W-1:0]    hlen_q, hlen_d;
  logic [BYTE_W-1:0]   obyte_q, obyte_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // Result register.
  logic [STATUS_W-1:0] res_status_q;
  logic [META_W-1:0]   res_meta_q;
  logic [LEN_W-1:0]    res_len_q;
  logic [BYTE_W-1:0]   res_byte_q;
  logic [USED_W-1:0]   res_used_q;
  logic                res_empty_q;

  // Memory port.
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]  rd_data;

  logic               in_accept;
  logic               res_load;
  logic [SUM_W-1:0]   need_sum;
  logic [META_W-1:0]  meta_sh;
  logic [BYTE_W-1:0]  hdr_byte;
  logic [HC_W-1:0]    cap_idx;
  logic [SUM_W-1:0]   used_ext;
  logic               read_mode;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign res_load      = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);
  assign need_sum      = SUM_W'(used_q) + HDR_SIZE + SUM_W'(len_in_q);
  assign meta_sh       = meta_in_q >> {cnt_q, 3'b000};
  assign cap_idx       = cnt_q - HC_W'(1);
  assign used_ext      = SUM_W'(used_q);
  assign read_mode     = (mode_q == MODE_READ_HDR) || (mode_q == MODE_READ_BYTE);

  // Header byte written at position cnt_q: meta low byte first, padding, length.
  always_comb begin
    hdr_byte = '0;
    if (SUM_W'(cnt_q) < SUM_W'(NMETA)) begin
      hdr_byte = meta_sh[BYTE_W-1:0];
    end else if (cnt_q == HC_W'(HEADER_BYTES - 2)) begin
      hdr_byte = len_in_q[7:0];
    end else if (cnt_q == HC_W'(HEADER_BYTES - 1)) begin
      hdr_byte = len_in_q[15:8];
    end
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    used_d    = used_q;
    pend_d    = pend_q;
    open_d    = open_q;
    psize_d   = psize_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    hmeta_d   = hmeta_q;
    hlen_d    = hlen_q;
    obyte_d   = obyte_q;
    status_d  = status_q;
    wr_en     = 1'b0;
    wr_addr   = wp_q;
    wr_data   = byte_in_q;
    rd_en     = 1'b0;
    rd_addr   = rp_q;

    if (res_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_d = ST_OK;
        hmeta_d  = '0;
        hlen_d   = '0;
        obyte_d  = '0;
        cnt_d    = '0;
        state_d  = S_FIN;
        case (mode_q)
          MODE_PUSH_START: begin
            if (open_q) begin
              status_d = ST_SEQ_ERR;
            end else if (need_sum >= BUF_SIZE) begin
              status_d = ST_NO_SPACE;
            end else begin
              state_d = S_HDR_WR;
            end
          end
          MODE_PUSH_BYTE: begin
            if (!open_q) begin
              status_d = ST_SEQ_ERR;
            end else begin
              wr_en  = 1'b1;
              wp_d   = ring_add(wp_q, SUM_W'(1));
              pend_d = pend_q - LEN_W'(1);
              if (pend_q == LEN_W'(1)) begin
                used_d  = used_q + psize_q[PTR_W-1:0];
                open_d  = 1'b0;
                psize_d = '0;
                pend_d  = '0;
              end
            end
          end
          MODE_READ_HDR, MODE_READ_BYTE, MODE_POP: begin
            if (used_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              state_d = S_HDR_RD;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_HDR_WR: begin
        wr_en   = 1'b1;
        wr_addr = ring_add(wp_q, SUM_W'(cnt_q));
        wr_data = hdr_byte;
        cnt_d   = cnt_q + HC_W'(1);
        if (cnt_q == HC_W'(HEADER_BYTES - 1)) begin
          state_d = S_FIN;
          wp_d    = ring_add(wp_q, HDR_SIZE);
          if (len_in_q == '0) begin
            // An empty payload commits the header alone right away.
            used_d = used_q + PTR_W'(HEADER_BYTES);
          end else begin
            open_d  = 1'b1;
            psize_d = (LEN_W + 1)'(HEADER_BYTES) + {1'b0, len_in_q};
            pend_d  = len_in_q;
          end
        end
      end
      S_HDR_RD: begin
        // Issue header reads; each byte is captured in the cycle after its address.
        if (cnt_q != HC_W'(HEADER_BYTES)) begin
          rd_en   = 1'b1;
          rd_addr = ring_add(rp_q, SUM_W'(cnt_q));
        end
        if (cnt_q != '0) begin
          for (int i = 0; i < 6; i++) begin
            if (i < NMETA && cap_idx == HC_W'(i)) begin
              hmeta_d[8*i +: 8] = rd_data;
            end
          end
          if (cap_idx == HC_W'(HEADER_BYTES - 2)) begin
            hlen_d[7:0] = rd_data;
          end
          if (cap_idx == HC_W'(HEADER_BYTES - 1)) begin
            hlen_d[15:8] = rd_data;
          end
        end
        cnt_d = cnt_q + HC_W'(1);
        if (cnt_q == HC_W'(HEADER_BYTES)) begin
          state_d = S_HDR_DONE;
        end
      end
      S_HDR_DONE: begin
        state_d = S_FIN;
        if (mode_q == MODE_POP) begin
          rp_d   = ring_add(rp_q, HDR_SIZE + SUM_W'(hlen_q));
          used_d = used_q - PTR_W'(HDR_SIZE + SUM_W'(hlen_q));
        end else if (mode_q == MODE_READ_BYTE && LEN_W'(ofs_q) < hlen_q) begin
          rd_en   = 1'b1;
          rd_addr = ring_add(rp_q, HDR_SIZE + SUM_W'(ofs_q));
          state_d = S_BYTE_RD;
        end
      end
      S_BYTE_RD: begin
        obyte_d = rd_data;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      used_q    <= '0;
      pend_q    <= '0;
      open_q    <= 1'b0;
      psize_q   <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      used_q    <= used_d;
      pend_q    <= pend_d;
      open_q    <= open_d;
      psize_q   <= psize_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q    <= s_axis_tuser;
      meta_in_q <= s_axis_tdata[47:0];
      len_in_q  <= s_axis_tdata[63:48];
      byte_in_q <= s_axis_tdata[71:64];
      ofs_q     <= s_axis_tdata[82:72];
    end
    hmeta_q  <= hmeta_d;
    hlen_q   <= hlen_d;
    obyte_q  <= obyte_d;
    status_q <= status_d;
    if (res_load) begin
      res_status_q <= status_q;
      res_meta_q   <= read_mode ? hmeta_q : '0;
      res_len_q    <= read_mode ? hlen_q : '0;
      res_byte_q   <= obyte_q;
      res_used_q   <= used_ext[USED_W-1:0];
      res_empty_q  <= (used_q == '0);
    end
  end

  vprf_ram #(
    .Width(BYTE_W),
    .Depth(BUFFER_BYTES)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {4'b0000, res_empty_q, res_used_q, res_byte_q, res_len_q, res_meta_q};

  // The committed count never reaches the ring size.
  a_used_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(used_q) < BUF_SIZE)
    else $error("committed byte count reached the ring size");

  // An open push always still expects at least one payload byte.
  a_open_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (pend_q != '0))
    else $error("push open with no payload bytes pending");

  // No second item is taken in the cycle after one was accepted.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("item accepted while another is in progress");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !res_load)
    else $error("held result overwritten");

  // Memory reads and writes never collide in this sequencer.
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("ring read and write issued in the same cycle");

endmodule
